// ===== hdl/sparse_tensor_mode_index_builder_macros.svh =====
// Assertion helpers for the index builder.
`ifndef SPARSE_TENSOR_MODE_INDEX_BUILDER_MACROS_SVH
`define SPARSE_TENSOR_MODE_INDEX_BUILDER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define STMIB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define STMIB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stmib_pkg.sv =====
package stmib_pkg;

    localparam int COORD_W   = 8;
    localparam int VALUE_W   = 11;
    localparam int NREG_DIMS = 4;

    // request opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_RD_CNT = 2'd1;
    localparam logic [1:0] OP_RD_WHR = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_COORD = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_POS   = 3'd3;
    localparam logic [2:0] ST_NOBLD = 3'd4;

    // register indexes, byte address is 4*index
    localparam logic [2:0] REG_MODES = 3'd0;
    localparam logic [2:0] REG_DIM0  = 3'd1;
    localparam logic [2:0] REG_DIM1  = 3'd2;
    localparam logic [2:0] REG_DIM2  = 3'd3;
    localparam logic [2:0] REG_DIM3  = 3'd4;

    // per-cycle commands from the sequencer to every mode lane
    typedef struct packed {
        logic cnt_clear;    // zero one count slot
        logic cnt_inc_rd;   // read count slot of coord+1
        logic cnt_inc_wr;   // write back incremented count
        logic pfx_rd;       // prefix sweep read of slot_addr
        logic coord_wr;     // store coordinate at entry_addr
        logic sc_coord_rd;  // scatter: fetch stored coordinate
        logic sc_cur_rd;    // scatter: fetch fill cursor
        logic sc_wr;        // scatter: write where entry, bump cursor
        logic rd_count;     // host read of count table
        logic rd_where;     // host read of where table
    } lane_ctl_t;

endpackage

// ===== hdl/stmib_ram.sv =====
module stmib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/stmib_lane.sv =====
// One mode: count table, fill cursors, stored coordinates, where table.
module stmib_lane #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_DIM     = 256
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  stmib_pkg::lane_ctl_t                       ctl,
    input  logic                                       lane_en,
    input  logic [$clog2(MAX_DIM + 1)-1:0]             slot_addr,
    input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] entry_addr,
    input  logic [stmib_pkg::COORD_W-1:0]              coord,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0]         count_q,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] where_q
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic          pend_reg;
    logic [DW-1:0] slot_d_reg;
    logic [CW-1:0] acc_reg;
    logic [CW-1:0] acc_sum;

    logic          cnt_we, cnt_re;
    logic [DW-1:0] cnt_waddr, cnt_raddr, inc_addr;
    logic [CW-1:0] cnt_wdata, cnt_rdata;

    logic          cur_we;
    logic [DW-1:0] cur_waddr;
    logic [CW-1:0] cur_wdata, cur_rdata;

    logic [stmib_pkg::COORD_W-1:0] crd_q;
    logic          coord_ok, pos_ok, sc_do;

    assign inc_addr = DW'(coord) + DW'(1);
    assign acc_sum  = acc_reg + cnt_rdata;

    // prefix sweep: read slot j, add and write it back in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            pend_reg <= ctl.pfx_rd & lane_en;
            acc_reg  <= pend_reg ? acc_sum : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_d_reg <= slot_addr;
    end

    assign cnt_re    = ctl.cnt_inc_rd | ctl.pfx_rd | ctl.rd_count;
    assign cnt_raddr = ctl.cnt_inc_rd ? inc_addr : slot_addr;
    assign cnt_we    = ctl.cnt_clear | (ctl.cnt_inc_wr & lane_en) | pend_reg;
    assign cnt_waddr = pend_reg ? slot_d_reg : (ctl.cnt_clear ? slot_addr : inc_addr);
    assign cnt_wdata = pend_reg ? acc_sum : (ctl.cnt_clear ? '0 : cnt_rdata + CW'(1));

    assign coord_ok = 32'(crd_q) < MAX_DIM;
    assign pos_ok   = 32'(cur_rdata) < MAX_ENTRIES;
    assign sc_do    = ctl.sc_wr & lane_en & coord_ok;

    assign cur_we    = pend_reg | sc_do;
    assign cur_waddr = pend_reg ? slot_d_reg : DW'(crd_q);
    assign cur_wdata = pend_reg ? acc_sum : cur_rdata + CW'(1);

    stmib_ram #(.WIDTH(CW), .DEPTH(MAX_DIM + 1)) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    stmib_ram #(.WIDTH(CW), .DEPTH(MAX_DIM + 1)) u_cursor (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .re    (ctl.sc_cur_rd),
        .raddr (DW'(crd_q)),
        .rdata (cur_rdata)
    );

    stmib_ram #(.WIDTH(stmib_pkg::COORD_W), .DEPTH(MAX_ENTRIES)) u_coord (
        .clk   (clk),
        .we    (ctl.coord_wr),
        .waddr (entry_addr),
        .wdata (coord),
        .re    (ctl.sc_coord_rd),
        .raddr (entry_addr),
        .rdata (crd_q)
    );

    stmib_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_where (
        .clk   (clk),
        .we    (sc_do & pos_ok),
        .waddr (EW'(cur_rdata)),
        .wdata (entry_addr),
        .re    (ctl.rd_where),
        .raddr (entry_addr),
        .rdata (where_q)
    );

    assign count_q = cnt_rdata;

endmodule

// ===== hdl/sparse_tensor_mode_index_builder.sv =====
// Channel   Handshake                     Payload
// config    psel/penable/pwrite, pready=1 paddr, pwdata, prdata
// request   start & !busy                 opcode, coord_mode0..3, last_entry,
//                                         mode_select, read_position
// result    done (one-cycle strobe)       read_value, status
//
// A load checks and stores the entry, then answers; a load after a build
// first clears the count tables. Table reads go through a read state and
// a result state; rejected reads are answered from idle. A last load adds
// the build: a prefix sweep over every slot, then a serial scatter of the
// stored entries through the cursor memories. After reset a clearing pass
// runs with busy high. The receiver cannot stall; one lane per mode works in
// parallel and the result stage picks the lane that a read addresses.
`include "sparse_tensor_mode_index_builder_macros.svh"

module sparse_tensor_mode_index_builder #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_MODES   = 4,
    parameter int MAX_DIM     = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  coord_mode0,
    input  logic [7:0]  coord_mode1,
    input  logic [7:0]  coord_mode2,
    input  logic [7:0]  coord_mode3,
    input  logic        last_entry,
    input  logic [1:0]  mode_select,
    input  logic [10:0] read_position,
    output logic        done,
    output logic [10:0] read_value,
    output logic [2:0]  status
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
    localparam int TW = $clog2(MAX_ENTRIES + 1);
    localparam int NR = stmib_pkg::NREG_DIMS;

    localparam logic [1:0] OP_LOAD   = stmib_pkg::OP_LOAD;
    localparam logic [1:0] OP_RD_CNT = stmib_pkg::OP_RD_CNT;
    localparam logic [1:0] OP_RD_WHR = stmib_pkg::OP_RD_WHR;

    localparam logic [2:0] ST_OK    = stmib_pkg::ST_OK;
    localparam logic [2:0] ST_COORD = stmib_pkg::ST_COORD;
    localparam logic [2:0] ST_FULL  = stmib_pkg::ST_FULL;
    localparam logic [2:0] ST_POS   = stmib_pkg::ST_POS;
    localparam logic [2:0] ST_NOBLD = stmib_pkg::ST_NOBLD;

    localparam logic [2:0] REG_MODES = stmib_pkg::REG_MODES;
    localparam logic [2:0] REG_DIM0  = stmib_pkg::REG_DIM0;
    localparam logic [2:0] REG_DIM1  = stmib_pkg::REG_DIM1;
    localparam logic [2:0] REG_DIM2  = stmib_pkg::REG_DIM2;
    localparam logic [2:0] REG_DIM3  = stmib_pkg::REG_DIM3;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_L1, S_L2, S_PFX, S_SA, S_SB, S_SC, S_RD, S_RD2
    } state_t;

    // ---------------- configuration registers ----------------
    logic [2:0] modes_reg;
    logic [8:0] dim_reg [NR];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= 3'd3;
            for (int i = 0; i < NR; i++)
            begin
                dim_reg[i] <= 9'd256;
            end
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_MODES: modes_reg  <= pwdata[2:0];
                REG_DIM0:  dim_reg[0] <= pwdata[8:0];
                REG_DIM1:  dim_reg[1] <= pwdata[8:0];
                REG_DIM2:  dim_reg[2] <= pwdata[8:0];
                REG_DIM3:  dim_reg[3] <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MODES: prdata = {29'd0, modes_reg};
            REG_DIM0:  prdata = {23'd0, dim_reg[0]};
            REG_DIM1:  prdata = {23'd0, dim_reg[1]};
            REG_DIM2:  prdata = {23'd0, dim_reg[2]};
            REG_DIM3:  prdata = {23'd0, dim_reg[3]};
            default:   prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // clamp a size register to 1..MAX_DIM
    function automatic logic [8:0] dim_clamp(input logic [8:0] d);
        logic [8:0] r;
        r = d;
        if (r == 9'd0)
        begin
            r = 9'd1;
        end
        if (32'(r) > MAX_DIM)
        begin
            r = 9'(MAX_DIM);
        end
        return r;
    endfunction

    logic [2:0] m_now;
    always_comb
    begin
        m_now = modes_reg;
        if (m_now == 3'd0)
        begin
            m_now = 3'd1;
        end
        if (32'(m_now) > MAX_MODES)
        begin
            m_now = 3'(MAX_MODES);
        end
    end

    // ---------------- sequencer state ----------------
    state_t        state_reg;
    logic [DW-1:0] slot_reg;
    logic [TW-1:0] total_reg;
    logic [TW-1:0] n_reg;
    logic          built_reg;
    logic          clr_load_reg;
    logic [1:0]    op_reg;
    logic [7:0]    coord_reg [NR];
    logic          last_reg;
    logic [1:0]    mode_reg;
    logic [10:0]   pos_reg;
    logic [2:0]    ld_st_reg;
    logic          done_reg;
    logic [10:0]   read_value_reg;
    logic [2:0]    status_reg;

    // load check: coordinate range per mode in use, then store capacity
    logic [2:0] ld_status;
    always_comb
    begin
        ld_status = ST_OK;
        for (int i = 0; i < NR; i++)
        begin
            if (i < 32'(m_now) && 9'(coord_reg[i]) >= dim_clamp(dim_reg[i]))
            begin
                ld_status = ST_COORD;
            end
        end
        if (ld_status == ST_OK && 32'(total_reg) >= MAX_ENTRIES)
        begin
            ld_status = ST_FULL;
        end
    end

    // read check at the request edge
    logic [2:0] rd_status;
    always_comb
    begin
        rd_status = ST_OK;
        if (!built_reg)
        begin
            rd_status = ST_NOBLD;
        end
        else if (3'(mode_select) >= m_now)
        begin
            rd_status = ST_POS;
        end
        else if (opcode == OP_RD_CNT)
        begin
            if (read_position > 11'(dim_clamp(dim_reg[mode_select])))
            begin
                rd_status = ST_POS;
            end
        end
        else if (32'(read_position) >= 32'(total_reg)
                 || 32'(read_position) >= MAX_ENTRIES)
        begin
            rd_status = ST_POS;
        end
    end

    // merge stage: pick the addressed lane's read data
    logic [TW-1:0] lane_count [MAX_MODES];
    logic [EW-1:0] lane_where [MAX_MODES];
    logic [10:0]   rd_q;
    always_comb
    begin
        rd_q = 11'd0;
        for (int i = 0; i < MAX_MODES; i++)
        begin
            if (32'(mode_reg) == i)
            begin
                rd_q = (op_reg == OP_RD_CNT) ? 11'(lane_count[i]) : 11'(lane_where[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            slot_reg       <= '0;
            total_reg      <= '0;
            n_reg          <= '0;
            built_reg      <= 1'b0;
            clr_load_reg   <= 1'b0;
            done_reg       <= 1'b0;
            read_value_reg <= '0;
            status_reg     <= ST_OK;
            ld_st_reg      <= ST_OK;
            op_reg         <= OP_LOAD;
            last_reg       <= 1'b0;
            mode_reg       <= '0;
            pos_reg        <= '0;
            for (int i = 0; i < NR; i++)
            begin
                coord_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    if (32'(slot_reg) == MAX_DIM)
                    begin
                        slot_reg     <= '0;
                        clr_load_reg <= 1'b0;
                        state_reg    <= clr_load_reg ? S_L1 : S_IDLE;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + DW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= opcode;
                        coord_reg[0] <= coord_mode0;
                        coord_reg[1] <= coord_mode1;
                        coord_reg[2] <= coord_mode2;
                        coord_reg[3] <= coord_mode3;
                        last_reg     <= last_entry;
                        mode_reg     <= mode_select;
                        pos_reg      <= read_position;
                        case (opcode)
                            OP_LOAD:
                            begin
                                if (built_reg)
                                begin
                                    total_reg    <= '0;
                                    built_reg    <= 1'b0;
                                    clr_load_reg <= 1'b1;
                                    slot_reg     <= '0;
                                    state_reg    <= S_CLR;
                                end
                                else
                                begin
                                    state_reg <= S_L1;
                                end
                            end
                            OP_RD_CNT, OP_RD_WHR:
                            begin
                                if (rd_status != ST_OK)
                                begin
                                    done_reg       <= 1'b1;
                                    read_value_reg <= '0;
                                    status_reg     <= rd_status;
                                end
                                else
                                begin
                                    state_reg <= S_RD;
                                end
                            end
                            default:
                            begin
                                done_reg       <= 1'b1;
                                read_value_reg <= '0;
                                status_reg     <= ST_POS;
                            end
                        endcase
                    end
                end
                S_L1:
                begin
                    ld_st_reg <= ld_status;
                    state_reg <= S_L2;
                end
                S_L2:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= ld_st_reg;
                    if (ld_st_reg == ST_OK)
                    begin
                        total_reg      <= total_reg + TW'(1);
                        read_value_reg <= 11'(total_reg + TW'(1));
                    end
                    else
                    begin
                        read_value_reg <= 11'(total_reg);
                    end
                    if (last_reg)
                    begin
                        slot_reg  <= '0;
                        state_reg <= S_PFX;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PFX:
                begin
                    if (32'(slot_reg) == MAX_DIM)
                    begin
                        slot_reg  <= '0;
                        n_reg     <= '0;
                        state_reg <= S_SA;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + DW'(1);
                    end
                end
                S_SA:
                begin
                    if (n_reg >= total_reg)
                    begin
                        built_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SB;
                    end
                end
                S_SB: state_reg <= S_SC;
                S_SC:
                begin
                    n_reg     <= n_reg + TW'(1);
                    state_reg <= S_SA;
                end
                S_RD: state_reg <= S_RD2;
                S_RD2:
                begin
                    done_reg       <= 1'b1;
                    read_value_reg <= rd_q;
                    status_reg     <= ST_OK;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    // ---------------- lane commands ----------------
    stmib_pkg::lane_ctl_t ctl;
    logic [DW-1:0]        lane_slot;
    logic [EW-1:0]        lane_entry;

    always_comb
    begin
        ctl        = '0;
        lane_slot  = slot_reg;
        lane_entry = EW'(n_reg);
        case (state_reg)
            S_CLR: ctl.cnt_clear = 1'b1;
            S_L1:
            begin
                lane_entry = EW'(total_reg);
                if (ld_status == ST_OK)
                begin
                    ctl.coord_wr   = 1'b1;
                    ctl.cnt_inc_rd = 1'b1;
                end
            end
            S_L2: ctl.cnt_inc_wr = (ld_st_reg == ST_OK);
            S_PFX: ctl.pfx_rd = 1'b1;
            S_SA: ctl.sc_coord_rd = (n_reg < total_reg);
            S_SB: ctl.sc_cur_rd = 1'b1;
            S_SC: ctl.sc_wr = 1'b1;
            S_RD:
            begin
                lane_slot    = DW'(pos_reg);
                lane_entry   = EW'(pos_reg);
                ctl.rd_count = (op_reg == OP_RD_CNT);
                ctl.rd_where = (op_reg != OP_RD_CNT);
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < MAX_MODES; g++)
    begin : g_lane
        logic [7:0] lane_coord;
        if (g < NR)
        begin : g_reg
            assign lane_coord = coord_reg[g];
        end
        else
        begin : g_zero
            assign lane_coord = 8'd0;
        end

        stmib_lane #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_DIM(MAX_DIM)) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .lane_en    (g < 32'(m_now)),
            .slot_addr  (lane_slot),
            .entry_addr (lane_entry),
            .coord      (lane_coord),
            .count_q    (lane_count[g]),
            .where_q    (lane_where[g])
        );
    end

    // ---------------- assertions ----------------
    `STMIB_ASSERT_NOW(a_no_done_in_clear, state_reg == S_CLR, !done_reg,
        "result during table clear")
    `STMIB_ASSERT_NOW(a_built_only_idle_or_read, built_reg,
        state_reg == S_IDLE || state_reg == S_RD || state_reg == S_RD2,
        "index marked built while loading or building")
    `STMIB_ASSERT_NOW(a_total_bound, 1'b1, 32'(total_reg) <= MAX_ENTRIES,
        "entry total beyond capacity")
    `STMIB_ASSERT_NEXT(a_request_progress, start && !busy, busy || done,
        "accepted request neither running nor answered")

endmodule

// ===== sim/tb_sparse_tensor_mode_index_builder.sv =====
`timescale 1ns / 100ps

module tb_sparse_tensor_mode_index_builder;

    // opcodes and status codes of the request/result fields
    localparam logic [1:0] OP_LOAD       = stmib_pkg::OP_LOAD;
    localparam logic [1:0] OP_READ_COUNT = stmib_pkg::OP_RD_CNT;
    localparam logic [1:0] OP_READ_WHERE = stmib_pkg::OP_RD_WHR;
    localparam logic [1:0] OP_UNUSED     = stmib_pkg::OP_UNUSED;

    localparam logic [2:0] ST_OK         = stmib_pkg::ST_OK;
    localparam logic [2:0] ST_COORD_OOR  = stmib_pkg::ST_COORD;
    localparam logic [2:0] ST_FULL       = stmib_pkg::ST_FULL;
    localparam logic [2:0] ST_POS_OOR    = stmib_pkg::ST_POS;
    localparam logic [2:0] ST_NOT_BUILT  = stmib_pkg::ST_NOBLD;

    // register indexes; byte address is 4*index
    localparam int REG_MODES = int'(stmib_pkg::REG_MODES);
    localparam int REG_DIM0  = int'(stmib_pkg::REG_DIM0);

    localparam int N_ENTRIES  = 1024;
    localparam int N_MODES    = 4;
    localparam int N_DIM      = 256;
    localparam int N_RANDOM   = 900;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  coord [N_MODES];
        logic        last;
        logic [1:0]  msel;
        logic [10:0] pos;
    } request_t;

    typedef struct {
        logic [10:0] value;
        logic [2:0]  code;
    } lookup_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  coord_mode0;
    logic [7:0]  coord_mode1;
    logic [7:0]  coord_mode2;
    logic [7:0]  coord_mode3;
    logic        last_entry;
    logic [1:0]  mode_select;
    logic [10:0] read_position;
    logic        done;
    logic [10:0] read_value;
    logic [2:0]  status;

    sparse_tensor_mode_index_builder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .coord_mode0   (coord_mode0),
        .coord_mode1   (coord_mode1),
        .coord_mode2   (coord_mode2),
        .coord_mode3   (coord_mode3),
        .last_entry    (last_entry),
        .mode_select   (mode_select),
        .read_position (read_position),
        .done          (done),
        .read_value    (read_value),
        .status        (status)
    );

    // ------------------------------------------------------------------
    // Index model: our own copy of registers, tables and counters
    // ------------------------------------------------------------------
    logic [2:0]  cfg_modes;
    logic [8:0]  cfg_dim [N_MODES];

    logic [7:0]  coord_store [N_ENTRIES][N_MODES];
    logic [10:0] slot_count  [N_MODES][N_DIM+1];
    logic [10:0] slot_cursor [N_MODES][N_DIM+1];
    logic [9:0]  entry_list  [N_MODES][N_ENTRIES];
    int          n_stored;
    bit          is_built;

    lookup_t     lookups_due [$];   // expected results, oldest first
    int          n_errors;
    int          n_sent;
    int          cycle_count;
    bit          gaps_on;           // phases with no idling clear this

    function automatic int modes_active();
        int m;
        m = cfg_modes;
        if (m < 1) m = 1;
        if (m > N_MODES) m = N_MODES;
        return m;
    endfunction

    function automatic int dim_active(int mode);
        int d;
        d = cfg_dim[mode];
        if (d < 1) d = 1;
        if (d > N_DIM) d = N_DIM;
        return d;
    endfunction

    function automatic void model_reset();
        cfg_modes = 3'd3;
        for (int i = 0; i < N_MODES; i++) cfg_dim[i] = 9'd256;
        for (int n = 0; n < N_ENTRIES; n++)
            for (int i = 0; i < N_MODES; i++)
            begin
                coord_store[n][i] = '0;
                entry_list[i][n]  = '0;
            end
        clear_counts();
    endfunction

    function automatic void clear_counts();
        for (int i = 0; i < N_MODES; i++)
            for (int j = 0; j <= N_DIM; j++)
            begin
                slot_count[i][j]  = '0;
                slot_cursor[i][j] = '0;
            end
        n_stored = 0;
        is_built = 0;
    endfunction

    // exclusive prefix sum per mode, then scatter in entry order
    function automatic void build_lists();
        int m;
        int c;
        int p;
        m = modes_active();
        for (int i = 0; i < m; i++)
        begin
            for (int j = 1; j <= N_DIM; j++)
                slot_count[i][j] = slot_count[i][j] + slot_count[i][j-1];
            for (int j = 0; j <= N_DIM; j++)
                slot_cursor[i][j] = slot_count[i][j];
        end
        for (int n = 0; n < n_stored; n++)
            for (int i = 0; i < m; i++)
            begin
                c = coord_store[n][i];
                p = slot_cursor[i][c];
                if (p < N_ENTRIES) entry_list[i][p] = n[9:0];
                slot_cursor[i][c] = p + 1;
            end
        is_built = 1;
    endfunction

    function automatic lookup_t predict_lookup(request_t r);
        lookup_t res;
        int      m;
        m = modes_active();
        res.value = '0;
        res.code  = ST_OK;
        if (r.op == OP_LOAD)
        begin
            if (is_built) clear_counts();
            for (int i = 0; i < m; i++)
                if (r.coord[i] >= dim_active(i)) res.code = ST_COORD_OOR;
            if (res.code == ST_OK && n_stored >= N_ENTRIES) res.code = ST_FULL;
            if (res.code == ST_OK)
            begin
                for (int i = 0; i < N_MODES; i++) coord_store[n_stored][i] = r.coord[i];
                for (int i = 0; i < m; i++)
                    slot_count[i][r.coord[i] + 1] = slot_count[i][r.coord[i] + 1] + 1;
                n_stored++;
            end
            res.value = n_stored[10:0];
            if (r.last) build_lists();
        end
        else if (r.op == OP_READ_COUNT || r.op == OP_READ_WHERE)
        begin
            if (!is_built) res.code = ST_NOT_BUILT;
            else if (r.msel >= m) res.code = ST_POS_OOR;
            else if (r.op == OP_READ_COUNT)
            begin
                if (r.pos > dim_active(r.msel)) res.code = ST_POS_OOR;
                else res.value = slot_count[r.msel][r.pos];
            end
            else
            begin
                if (r.pos >= n_stored) res.code = ST_POS_OOR;
                else res.value = {1'b0, entry_list[r.msel][r.pos]};
            end
        end
        else
            res.code = ST_POS_OOR;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle cap, result checker
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int expected, int got);
        $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, expected, got);
        n_errors++;
    endtask

    // done, read_value and status are sampled before the edge updates them
    always @(posedge clk)
    begin
        lookup_t exp_res;
        if (rst_n && done)
        begin
            if (lookups_due.size() == 0)
                report_mismatch("result with none pending", 0, read_value);
            else
            begin
                exp_res = lookups_due.pop_front();
                if (read_value !== exp_res.value)
                    report_mismatch("read_value", exp_res.value, read_value);
                if (status !== exp_res.code)
                    report_mismatch("status", exp_res.code, status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge. Start is only lowered when a gap follows, so
    // back-to-back requests keep it high without a second assignment.
    task automatic send_request(request_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        opcode        <= r.op;
        coord_mode0   <= r.coord[0];
        coord_mode1   <= r.coord[1];
        coord_mode2   <= r.coord[2];
        coord_mode3   <= r.coord[3];
        last_entry    <= r.last;
        mode_select   <= r.msel;
        read_position <= r.pos;
        do @(posedge clk); while (busy);
        lookups_due.push_back(predict_lookup(r));
        n_sent++;
    endtask

    // wait for every pending result, then for the block to go idle
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (lookups_due.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(int idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MODES) cfg_modes = val[2:0];
        else cfg_dim[idx - REG_DIM0] = val[8:0];
        @(posedge clk);
    endtask

    task automatic set_shape(logic [31:0] modes, logic [31:0] d0, logic [31:0] d1,
                             logic [31:0] d2, logic [31:0] d3);
        write_reg(REG_MODES, modes);
        write_reg(REG_DIM0 + 0, d0);
        write_reg(REG_DIM0 + 1, d1);
        write_reg(REG_DIM0 + 2, d2);
        write_reg(REG_DIM0 + 3, d3);
    endtask

    function automatic request_t make_load(int c0, int c1, int c2, int c3, bit last);
        request_t r;
        r.op       = OP_LOAD;
        r.coord[0] = c0[7:0];
        r.coord[1] = c1[7:0];
        r.coord[2] = c2[7:0];
        r.coord[3] = c3[7:0];
        r.last     = last;
        r.msel     = 2'($urandom_range(0, 3));
        r.pos      = 11'($urandom_range(0, 2047));
        return r;
    endfunction

    function automatic request_t make_read(logic [1:0] op, int mode, int pos);
        request_t r;
        r.op   = op;
        for (int i = 0; i < N_MODES; i++) r.coord[i] = 8'($urandom_range(0, 255));
        r.last = 1'($urandom_range(0, 1));
        r.msel = mode[1:0];
        r.pos  = pos[10:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reads before any build, and the unused opcode
    task automatic test_before_build();
        send_request(make_read(OP_READ_COUNT, 0, 0));
        send_request(make_read(OP_READ_WHERE, 3, 2047));
        send_request(make_read(OP_UNUSED, 1, 5));
        wait_drained();
    endtask

    // field extremes, a rejected coordinate, table reads at the edges,
    // then a rejected last load after a build giving an empty index
    task automatic test_directed_edges();
        set_shape(4, 256, 1, 17, 256);
        send_request(make_load(0, 0, 0, 0, 0));
        send_request(make_load(255, 0, 16, 255, 0));
        send_request(make_load(10, 1, 3, 3, 0));            // mode 1 out of range
        send_request(make_load(3, 0, 16, 0, 1));            // last: build
        send_request(make_read(OP_READ_COUNT, 0, 0));
        send_request(make_read(OP_READ_COUNT, 0, 256));
        send_request(make_read(OP_READ_COUNT, 0, 257));
        send_request(make_read(OP_READ_COUNT, 1, 1));
        send_request(make_read(OP_READ_COUNT, 2, 17));
        send_request(make_read(OP_READ_WHERE, 3, 0));
        send_request(make_read(OP_READ_WHERE, 2, 2));
        send_request(make_read(OP_READ_WHERE, 0, 3));
        send_request(make_read(OP_READ_WHERE, 1, 1024));
        // load after the build clears the tables, is rejected, and builds empty
        send_request(make_load(0, 200, 0, 0, 1));
        send_request(make_read(OP_READ_COUNT, 3, 256));
        send_request(make_read(OP_READ_WHERE, 0, 0));
        wait_drained();
        // fewer modes: reads of modes not in use are rejected
        set_shape(1, 0, 300, 511, 2);
        send_request(make_load(0, 255, 255, 255, 1));
        send_request(make_read(OP_READ_COUNT, 0, 1));
        send_request(make_read(OP_READ_WHERE, 1, 0));
        send_request(make_read(OP_READ_COUNT, 3, 0));
        wait_drained();
    endtask

    // fill the store, overflow it, build over the full set
    task automatic test_store_full();
        gaps_on = 0;
        set_shape(1, 1, 256, 256, 256);
        for (int n = 0; n < N_ENTRIES; n++)
            send_request(make_load(0, $urandom_range(0, 255), 0, 0, 0));
        send_request(make_load(0, 0, 0, 0, 0));             // store full
        send_request(make_load(0, 0, 0, 0, 1));             // full and last: build
        send_request(make_read(OP_READ_COUNT, 0, 1));
        send_request(make_read(OP_READ_WHERE, 0, 1023));
        send_request(make_read(OP_READ_WHERE, 0, 1024));
        wait_drained();
        gaps_on = 1;
    endtask

    function automatic logic [31:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return 1;
        if (r == 2) return 256;
        if (r == 3) return $urandom_range(257, 511);
        if (r < 7) return $urandom_range(2, 16);
        return $urandom_range(2, 255);
    endfunction

    // shapes, load sets of random size, a build, then a burst of reads
    task automatic test_random_sets();
        int       n_loads;
        int       n_reads;
        int       m;
        int       c [N_MODES];
        int       r;
        request_t rq;
        // the full-store test alone sends over a thousand requests
        while (n_sent < N_RANDOM + 250)
        begin
            gaps_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 2) == 0)
                set_shape($urandom_range(0, 7), pick_dim(), pick_dim(), pick_dim(), pick_dim());
            m = modes_active();
            n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(0, 24);
            for (int k = 0; k < n_loads; k++)
            begin
                for (int i = 0; i < N_MODES; i++)
                    c[i] = (i < m) ? $urandom_range(0, dim_active(i) - 1)
                                   : $urandom_range(0, 255);
                if ($urandom_range(0, 9) == 0)
                    c[$urandom_range(0, N_MODES - 1)] = $urandom_range(0, 255);
                send_request(make_load(c[0], c[1], c[2], c[3], 0));
                // noise: a request with a random opcode, often a read before the build
                if ($urandom_range(0, 15) == 0)
                    send_request(make_read(2'($urandom_range(0, 3)),
                                           $urandom_range(0, 3), $urandom_range(0, 2047)));
            end
            for (int i = 0; i < N_MODES; i++) c[i] = $urandom_range(0, 255);
            send_request(make_load(c[0], c[1], c[2], c[3], 1));
            n_reads = $urandom_range(5, 30);
            for (int k = 0; k < n_reads; k++)
            begin
                r = $urandom_range(0, 19);
                if (r < 8)
                    rq = make_read(OP_READ_COUNT, $urandom_range(0, m - 1),
                                   $urandom_range(0, dim_active(0)));
                else if (r < 16)
                    rq = make_read(OP_READ_WHERE, $urandom_range(0, m - 1),
                                   $urandom_range(0, n_stored > 0 ? n_stored - 1 : 0));
                else
                    rq = make_read(2'($urandom_range(1, 3)), $urandom_range(0, 3),
                                   $urandom_range(0, 2047));
                send_request(rq);
            end
            // hold off the sender until every pending result is back
            wait_drained();
        end
    endtask

    initial
    begin
        n_errors    = 0;
        n_sent      = 0;
        cycle_count = 0;
        gaps_on     = 1;
        model_reset();
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        start         <= 1'b0;
        opcode        <= OP_LOAD;
        coord_mode0   <= '0;
        coord_mode1   <= '0;
        coord_mode2   <= '0;
        coord_mode3   <= '0;
        last_entry    <= 1'b0;
        mode_select   <= '0;
        read_position <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_build();
        test_directed_edges();
        test_store_full();
        test_random_sets();

        // wait_drained has run; keep clocking to catch a stray strobe
        repeat (20) @(posedge clk);
        if (lookups_due.size() != 0)
            report_mismatch("results never seen", 0, lookups_due.size());
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
